// ===== design/mrfs_pkg.sv =====
// Shared types, byte codes and helpers of the modem receive frame splitter.
`timescale 1ns / 1ps

package mrfs_pkg;

   // Default depth of the frame store
   localparam int STORE_DEPTH_DEF = 64;

   // Framing byte codes
   localparam logic [7:0] BYTE_STX    = 8'h02;
   localparam logic [7:0] BYTE_ETX    = 8'h03;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   // Shortest data frame that can hold a check, terminator included
   localparam int DATA_MIN_LEN = 4;
   // An AT line is emitted only once it is longer than this
   localparam int AT_MIN_LEN   = 4;

   // Frame kind codes on the response channel
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_AT   = 1'b1;

   // Kind of frame being collected
   typedef enum logic [1:0] {
      MODE_DATA = 2'd0,
      MODE_AT   = 2'd1,
      MODE_NONE = 2'd2
   } mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   // Read request handed to the output stage
   typedef struct packed {
      logic issue;
      logic last;
      logic kind;
   } emit_req_type;

   // ASCII hex character of one nibble
   function automatic logic [7:0] nibble_char(input logic [3:0] nib, input logic upper);
      logic [3:0] n;
      begin
         n = nib & NIBBLE_MASK;
         if (n < 4'd10) begin
            nibble_char = 8'h30 + {4'd0, n};
         end else if (upper) begin
            nibble_char = 8'h41 + {4'd0, n - 4'd10};
         end else begin
            nibble_char = 8'h61 + {4'd0, n - 4'd10};
         end
      end
   endfunction

endpackage

// ===== design/modem_rx_frame_splitter_core.sv =====
// Modem receive frame splitter: top level with framing sequencer and check pass.
`timescale 1ns / 1ps

// Each accepted request byte of a data or AT frame is written into the frame
// store while it has room. A terminator that closes a data frame of n bytes
// starts a check pass that reads the n-1 bytes before it over the store's
// single read port, and on a match an emit pass follows, one response per
// cycle while rsp_stall stays low. A finished AT line of n bytes goes straight
// to the emit pass. The request channel stalls during both passes, and both
// passes are held up while the response side holds off. The last response may
// still wait in the output register while the next request is taken. The
// user writes csr_wr_data (hex_upper_ff, set by csr_wr_en) only while the
// block is idle; the block does not enforce this. It selects the case of the
// hex check digits.
module modem_rx_frame_splitter_core
   import mrfs_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_kind,
   output logic       rsp_last_byte,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(STORE_DEPTH);
   localparam logic [CNT_W-1:0] DATA_MIN  = CNT_W'(DATA_MIN_LEN);
   localparam logic [CNT_W-1:0] AT_MIN    = CNT_W'(AT_MIN_LEN);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             kind_ff, kind_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       hi_ff, hi_in;
   logic             rdv_ff;
   logic [CNT_W-1:0] rdi_ff;
   logic             hex_upper_ff;

   logic             accept;
   mode_type         mode_sel;
   logic [CNT_W-1:0] base;
   logic             do_store;
   logic [CNT_W-1:0] cnt_new;
   logic             wr_en;
   logic [CNT_W-1:0] len_m2, len_m3;
   logic             chk_issue, emt_issue;
   logic             can_issue, emit_busy;
   logic             match;
   logic [7:0]       rd_data;
   emit_req_type     emit_req;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Pick the frame kind on an empty store, else keep the current one
   always_comb begin
      mode_sel = mode_ff;
      if (fill_ff == '0) begin
         if (req_rx_byte == BYTE_STX) begin
            mode_sel = MODE_DATA;
         end else if (req_rx_byte == BYTE_CR) begin
            mode_sel = MODE_AT;
         end else begin
            mode_sel = MODE_NONE;
         end
      end
   end

   // Store position after a restart, and the fill after the store
   always_comb begin
      base = fill_ff;
      case (mode_sel)
         MODE_DATA: begin
            if (req_rx_byte == BYTE_STX) begin
               base = '0;
            end
         end
         MODE_AT: begin
            if (fill_ff <= CNT_ONE && req_rx_byte == BYTE_CR) begin
               base = '0;
            end
         end
         default: begin
            base = fill_ff;
         end
      endcase
      do_store = (base < DEPTH_C) && (mode_sel == MODE_DATA || mode_sel == MODE_AT);
      cnt_new  = base + CNT_W'(do_store);
   end

   assign wr_en = accept && do_store;

   assign len_m2 = len_ff - CNT_TWO;
   assign len_m3 = len_ff - CNT_THREE;

   // Check reads wait for the output stage so its held read data is not lost
   assign chk_issue = (state_ff == ST_CHECK) && !emit_busy && (cnt_ff <= len_m2);
   assign emt_issue = (state_ff == ST_EMIT) && can_issue;

   assign match = (hi_ff == nibble_char(xor_ff[7:4], hex_upper_ff)) &&
                  (rd_data == nibble_char(xor_ff[3:0], hex_upper_ff));

   always_comb begin
      emit_req.issue = emt_issue;
      emit_req.last  = ((cnt_ff + CNT_ONE) == len_ff);
      emit_req.kind  = kind_ff;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      xor_in   = xor_ff;
      hi_in    = hi_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = mode_sel;
               case (mode_sel)
                  MODE_DATA: begin
                     fill_in = cnt_new;
                     if (req_rx_byte == BYTE_ETX) begin
                        fill_in = '0;
                        if (do_store && cnt_new >= DATA_MIN) begin
                           state_in = ST_CHECK;
                           len_in   = cnt_new;
                           cnt_in   = '0;
                           xor_in   = '0;
                           kind_in  = KIND_DATA;
                        end
                     end
                  end
                  MODE_AT: begin
                     fill_in = cnt_new;
                     if (cnt_new > AT_MIN && req_rx_byte == BYTE_LF) begin
                        fill_in  = '0;
                        state_in = ST_EMIT;
                        len_in   = cnt_new;
                        cnt_in   = '0;
                        kind_in  = KIND_AT;
                     end
                  end
                  default: begin
                     fill_in = fill_ff;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (chk_issue) begin
               cnt_in = cnt_ff + CNT_ONE;
            end
            // Fold in returning bytes, then compare on the second check digit
            if (rdv_ff) begin
               if (rdi_ff < len_m3) begin
                  xor_in = xor_ff ^ rd_data;
               end else if (rdi_ff == len_m3) begin
                  hi_in = rd_data;
               end else begin
                  cnt_in   = '0;
                  state_in = match ? ST_EMIT : ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (emt_issue) begin
               cnt_in = cnt_ff + CNT_ONE;
               if (emit_req.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_NONE;
         fill_ff      <= '0;
         rdv_ff       <= 1'b0;
         hex_upper_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         fill_ff  <= fill_in;
         rdv_ff   <= chk_issue;
         if (csr_wr_en) begin
            hex_upper_ff <= csr_wr_data;
         end
      end
   end

   // Pass counters and check accumulators
   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      kind_ff <= kind_in;
      xor_ff  <= xor_in;
      hi_ff   <= hi_in;
      rdi_ff  <= cnt_ff;
   end

   mrfs_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (base[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (chk_issue || emt_issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   mrfs_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .emit_req       (emit_req),
      .rd_data        (rd_data),
      .can_issue      (can_issue),
      .busy           (emit_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_last_byte  (rsp_last_byte)
   );

`ifndef ASSERT_OFF
   // Fill never runs past the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("fill count beyond store depth");

   // A check pass only runs on a frame long enough to carry check digits
   a_check_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (len_ff >= DATA_MIN && len_ff <= DEPTH_C))
      else $error("check pass on a short frame");

   // A check read never overwrites read data still owed to the output stage
   a_check_read: assert property (@(posedge clock) disable iff (reset)
      chk_issue |-> !emit_busy)
      else $error("check read while output read in flight");

   // The store is written only while bytes are being taken
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("store write outside idle");
`endif

endmodule

// ===== design/mrfs_store.sv =====
// Frame byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mrfs_store
   import mrfs_pkg::*;
#(
   parameter int DEPTH = STORE_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write one received byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one byte; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mrfs_emit.sv =====
// Output stage: catches store read data and presents it on the response channel.
`timescale 1ns / 1ps

module mrfs_emit
   import mrfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  emit_req_type emit_req,
   input  logic [7:0]   rd_data,
   output logic         can_issue,
   output logic         busy,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_frame_byte,
   output logic         rsp_frame_kind,
   output logic         rsp_last_byte
);

   logic       inflight_ff, inflight_in;
   logic       pend_last_ff, pend_kind_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_kind_ff, rsp_last_ff;
   logic       load;

   // Move read data into the response register when it is free or being taken
   assign load      = inflight_ff && (!rsp_valid_ff || !rsp_stall);
   assign can_issue = !inflight_ff || load;
   assign busy      = inflight_ff;

   always_comb begin
      inflight_in = inflight_ff;
      if (emit_req.issue) begin
         inflight_in = 1'b1;
      end else if (load) begin
         inflight_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tag of the read in flight, and the response payload
   always_ff @(posedge clock) begin
      if (emit_req.issue) begin
         pend_last_ff <= emit_req.last;
         pend_kind_ff <= emit_req.kind;
      end
      if (load) begin
         rsp_byte_ff <= rd_data;
         rsp_kind_ff <= pend_kind_ff;
         rsp_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_kind = rsp_kind_ff;
   assign rsp_last_byte  = rsp_last_ff;

endmodule
